// File: src/bpe_pkg.sv
package bpe_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int MAX_CHARS = 5;
	localparam int GRP_CHARS = 4;
	localparam int CNT_W = 3;

	// Type characters and fixed bits
	localparam logic [CHAR_W-1:0] TYPE_Z1_LOW    = 7'h23;
	localparam logic [CHAR_W-1:0] TYPE_Z1_HIGH   = 7'h27;
	localparam logic [CHAR_W-1:0] TYPE_ZZ        = 7'h43;
	localparam logic [CHAR_W-1:0] ZZ_FIRST_HIGH  = 7'h20;
	localparam logic [CHAR_W-1:0] ZZ_SECOND_HIGH = 7'h04;
	localparam logic [CHAR_W-1:0] ZDATA_LOW_TOP  = 7'h20;
	localparam logic [CHAR_W-1:0] TYPE_MARK      = 7'h01;

	localparam logic [1:0] LEN_NONE   = 2'd0;
	localparam logic [1:0] LEN_SINGLE = 2'd1;
	localparam logic [1:0] LEN_PAIR   = 2'd2;
	localparam logic [1:0] LEN_TRIPLE = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0]                  n_chars;
		logic [GRP_CHARS-1:0][CHAR_W-1:0]  chars;
	} bpe_grp_t;

	// Result of one transaction through the grouping logic
	typedef struct packed {
		logic [CNT_W-1:0]                  n_chars;
		logic [MAX_CHARS-1:0][CHAR_W-1:0]  chars;
		logic [1:0]                        pend_cnt;
		logic [BYTE_W-1:0]                 pend_first;
		logic [BYTE_W-1:0]                 pend_second;
	} bpe_step_t;

	function automatic logic is_z(input logic [BYTE_W-1:0] b);
		return b[5:4] == 2'b00;
	endfunction

	function automatic logic is_pass(input logic [BYTE_W-1:0] b);
		return (b[5:4] != 2'b00) && (b[7:6] == 2'b00);
	endfunction

	function automatic logic [CHAR_W-1:0] zdata(input logic [BYTE_W-1:0] b);
		logic [CHAR_W-1:0] c;
		c = {2'b00, b[3:0], 1'b0};
		if (b[7:6] == 2'b00) begin
			c = c | ZDATA_LOW_TOP;
		end else begin
			c = c | {b[7:6], 5'b00000};
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] hdata(input logic [BYTE_W-1:0] b);
		return {b[5:0], 1'b0};
	endfunction

	// Group length at the head of the window, LEN_NONE while undecided
	function automatic logic [1:0] decide(
		input logic [BYTE_W-1:0] b0,
		input logic [BYTE_W-1:0] b1,
		input logic [BYTE_W-1:0] b2,
		input logic [1:0]        n,
		input logic              fin
	);
		logic [1:0] len;
		if (n == 2'd0) begin
			len = LEN_NONE;
		end else if (is_pass(b0)) begin
			len = LEN_SINGLE;
		end else if (n == 2'd1) begin
			len = fin ? LEN_SINGLE : LEN_NONE;
		end else if (is_pass(b1) || (is_z(b0) != is_z(b1))) begin
			len = LEN_SINGLE;
		end else if (is_z(b0)) begin
			len = LEN_PAIR;
		end else if (n == 2'd2) begin
			len = fin ? LEN_PAIR : LEN_NONE;
		end else if (is_z(b2) || (b2[7:6] == 2'b00)) begin
			len = LEN_PAIR;
		end else if ((b0[7:6] == 2'b11) && (b1[7:6] == 2'b11) && (b2[7:6] == 2'b11)) begin
			len = LEN_PAIR;
		end else begin
			len = LEN_TRIPLE;
		end
		return len;
	endfunction

	function automatic bpe_grp_t encode_group(
		input logic [BYTE_W-1:0] b0,
		input logic [BYTE_W-1:0] b1,
		input logic [BYTE_W-1:0] b2,
		input logic [1:0]        len
	);
		bpe_grp_t g;
		logic [CHAR_W-1:0] t;
		g = '0;
		t = TYPE_ZZ;
		case (len)
			LEN_SINGLE: begin
				if (is_z(b0)) begin
					g.chars[0] = (b0[7:6] == 2'b00) ? TYPE_Z1_LOW : TYPE_Z1_HIGH;
					g.chars[1] = zdata(b0);
					g.n_chars = 3'd2;
				end else if (is_pass(b0)) begin
					g.chars[0] = hdata(b0);
					g.n_chars = 3'd1;
				end else begin
					g.chars[0] = {b0[7:6], 5'b00000} | TYPE_MARK;
					g.chars[1] = hdata(b0);
					g.n_chars = 3'd2;
				end
			end
			LEN_PAIR: begin
				if (is_z(b0)) begin
					if (b0[7:6] != 2'b00) begin
						t = t | ZZ_FIRST_HIGH;
					end
					if (b1[7:6] != 2'b00) begin
						t = t | ZZ_SECOND_HIGH;
					end
					g.chars[0] = t;
					g.chars[1] = zdata(b0);
					g.chars[2] = zdata(b1);
				end else begin
					g.chars[0] = {b0[7:6], b1[7:6], 3'b000} | TYPE_MARK;
					g.chars[1] = hdata(b0);
					g.chars[2] = hdata(b1);
				end
				g.n_chars = 3'd3;
			end
			LEN_TRIPLE: begin
				g.chars[0] = {b0[7:6], b1[7:6], b2[7:6], 1'b0} | TYPE_MARK;
				g.chars[1] = hdata(b0);
				g.chars[2] = hdata(b1);
				g.chars[3] = hdata(b2);
				g.n_chars = 3'd4;
			end
			default: begin
				g = '0;
			end
		endcase
		return g;
	endfunction

endpackage

// File: src/bpe_byte_if.sv
interface bpe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       block_end;

	modport source(output valid, output in_byte, output block_end, input ready);
	modport sink(input valid, input in_byte, input block_end, output ready);
endinterface

// File: src/bpe_char_if.sv
interface bpe_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       run_last;

	modport source(output valid, output out_char, output run_last, input ready);
	modport sink(input valid, input out_char, input run_last, output ready);
endinterface

// File: src/bpe_group.sv
module bpe_group (
	input  logic [1:0]                  pend_cnt,
	input  logic [bpe_pkg::BYTE_W-1:0]  pend_first,
	input  logic [bpe_pkg::BYTE_W-1:0]  pend_second,
	input  logic [bpe_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        block_end,
	output bpe_pkg::bpe_step_t          step
);
	import bpe_pkg::*;

	logic [BYTE_W-1:0] b0, b1, b2;
	logic [BYTE_W-1:0] r0, r1;
	logic [1:0]        n0, n1, n2;
	logic [1:0]        len1, len2;
	bpe_grp_t          g1, g2;

	// Window: held bytes first, then the new byte
	always_comb begin
		b0 = in_byte;
		b1 = in_byte;
		b2 = in_byte;
		case (pend_cnt)
			2'd1: begin
				b0 = pend_first;
			end
			2'd2: begin
				b0 = pend_first;
				b1 = pend_second;
			end
			default: begin
				b0 = in_byte;
			end
		endcase
		n0 = 2'(pend_cnt + 2'd1);
	end

	// First group
	always_comb begin
		len1 = decide(b0, b1, b2, n0, block_end);
		g1 = encode_group(b0, b1, b2, len1);
		n1 = 2'(n0 - len1);
		case (len1)
			LEN_SINGLE: begin
				r0 = b1;
				r1 = b2;
			end
			LEN_PAIR: begin
				r0 = b2;
				r1 = b2;
			end
			default: begin
				r0 = b0;
				r1 = b1;
			end
		endcase
	end

	// Second group; the window holds at most two groups
	always_comb begin
		len2 = (len1 == LEN_NONE) ? LEN_NONE : decide(r0, r1, r1, n1, block_end);
		g2 = encode_group(r0, r1, r1, len2);
		n2 = 2'(n1 - len2);
	end

	always_comb begin
		step = '0;
		step.n_chars = 3'(g1.n_chars + g2.n_chars);
		case (g1.n_chars)
			3'd1: step.chars = {g2.chars[3:0], g1.chars[0]};
			3'd2: step.chars = {g2.chars[2:0], g1.chars[1:0]};
			3'd3: step.chars = {g2.chars[1:0], g1.chars[2:0]};
			3'd4: step.chars = {g2.chars[0], g1.chars[3:0]};
			default: step.chars = '0;
		endcase
		step.pend_cnt = n2;
		case (len2)
			LEN_SINGLE: begin
				step.pend_first = r1;
				step.pend_second = r1;
			end
			default: begin
				step.pend_first = r0;
				step.pend_second = r1;
			end
		endcase
	end

endmodule

// File: src/binary_to_printable_encoder.sv
// Channel   Dir  Payload               Per transaction
// byte_ch   in   in_byte, block_end    one raw byte
// char_ch   out  out_char, run_last    one printable character
//
// A byte is registered, then grouped and encoded in one pass into a
// five-character output buffer that drains one character per cycle while
// char_ch is ready; the next byte moves in as the last character leaves.
// Reset empties the input stage and the output buffer and clears the held-byte count.
// A stall on char_ch holds the buffer; the input stage still takes one more byte.
// run_last marks the last character released by a byte; a byte that is only
// held releases nothing.
module binary_to_printable_encoder (
	input  logic              clk,
	input  logic              arst_n,
	bpe_byte_if.sink          byte_ch,
	bpe_char_if.source        char_ch
);
	import bpe_pkg::*;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;

	// Lookahead of held bytes
	logic [1:0]        pend_cnt_q;
	logic [BYTE_W-1:0] pend_first_q;
	logic [BYTE_W-1:0] pend_second_q;

	// Output buffer, oldest character at index 0
	logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_q;
	logic [CNT_W-1:0]                 rem_q;

	bpe_step_t step;
	logic      out_fire;
	logic      buf_free;
	logic      move;
	logic      in_fire;

	bpe_group u_group (
		.pend_cnt    (pend_cnt_q),
		.pend_first  (pend_first_q),
		.pend_second (pend_second_q),
		.in_byte     (byte_s1),
		.block_end   (end_s1),
		.step        (step)
	);

	assign out_fire = char_ch.valid && char_ch.ready;
	// Buffer is empty now or after this cycle's transaction
	assign buf_free = (rem_q == '0) || ((rem_q == CNT_W'(1)) && char_ch.ready);
	assign move     = valid_s1 && buf_free;
	assign byte_ch.ready = !valid_s1 || move;
	assign in_fire  = byte_ch.valid && byte_ch.ready;

	assign char_ch.valid    = rem_q != '0;
	assign char_ch.out_char = chars_q[0];
	assign char_ch.run_last = rem_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			pend_cnt_q <= 2'd0;
			rem_q      <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				pend_cnt_q <= step.pend_cnt;
				rem_q      <= step.n_chars;
			end else if (out_fire) begin
				rem_q <= CNT_W'(rem_q - CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= byte_ch.in_byte;
			end_s1  <= byte_ch.block_end;
		end
		if (move) begin
			pend_first_q  <= step.pend_first;
			pend_second_q <= step.pend_second;
			chars_q       <= step.chars;
		end else if (out_fire) begin
			chars_q <= {CHAR_W'(0), chars_q[MAX_CHARS-1:1]};
		end
	end

endmodule

// File: verif/tb_binary_to_printable_encoder.sv
`timescale 1ns / 100ps

module tb_binary_to_printable_encoder;
	import bpe_pkg::*;

	// Run bounds.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYC   = 20;
	localparam int ITEMS_PER_PH = 160;
	localparam int MAX_REPORTS  = 40;

	// One raw byte as the source side offers it
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              fin;
	} byte_item_t;

	// One character the block owes us
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_t;

	logic clk = 1'b0;
	logic arst_n;

	bpe_byte_if byte_ch();
	bpe_char_if char_ch();

	binary_to_printable_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.char_ch(char_ch)
	);

	always #10 clk = ~clk;

	// Stimulus waiting for the source side, and characters still owed by the block
	byte_item_t byte_items[$];
	char_t      owed_chars[$];

	// Lookahead copy: bytes whose group is still undecided
	logic [1:0][BYTE_W-1:0] held;
	int                     held_n = 0;

	// Idle percentages, changed only on the falling edge
	int src_idle = 0;
	int snk_idle = 0;

	int errors     = 0;
	int bytes_in   = 0;
	int chars_out  = 0;
	int ends_in    = 0;
	int cycles     = 0;

	byte_item_t nxt;
	char_t      want;

	//------------------------------------------------------------------
	// Byte classes: plain bytes (top bits 00, middle nonzero) go out alone;
	// zero-middle bytes and high bytes get a type character.
	//------------------------------------------------------------------
	function automatic logic plain(input logic [BYTE_W-1:0] b);
		return (b[5:4] != 2'b00) && (b[7:6] == 2'b00);
	endfunction

	function automatic logic zero_mid(input logic [BYTE_W-1:0] b);
		return b[5:4] == 2'b00;
	endfunction

	// Data char of a zero-middle byte: top pair moves into bits 6..5,
	// a zero top pair becomes 01 so the char stays printable
	function automatic logic [CHAR_W-1:0] zmid_char(input logic [BYTE_W-1:0] b);
		return (b[7:6] == 2'b00) ? {2'b01, b[3:0], 1'b0} : {b[7:6], b[3:0], 1'b0};
	endfunction

	function automatic logic [CHAR_W-1:0] low6_char(input logic [BYTE_W-1:0] b);
		return {b[5:0], 1'b0};
	endfunction

	// How many bytes at the head of the window form the next group;
	// LEN_NONE when more lookahead is needed
	function automatic logic [1:0] group_len(input logic [2:0][BYTE_W-1:0] w, input int n,
			input logic fin);
		if (n == 0)
			return LEN_NONE;
		if (plain(w[0]))
			return LEN_SINGLE;
		if (n == 1)
			return fin ? LEN_SINGLE : LEN_NONE;
		if (plain(w[1]) || (zero_mid(w[0]) != zero_mid(w[1])))
			return LEN_SINGLE;
		if (zero_mid(w[0]))
			return LEN_PAIR;
		if (n == 2)
			return fin ? LEN_PAIR : LEN_NONE;
		if (zero_mid(w[2]) || (w[2][7:6] == 2'b00))
			return LEN_PAIR;
		// three 11 top pairs would make the type char 0x7F: split
		if (&{w[0][7:6], w[1][7:6], w[2][7:6]})
			return LEN_PAIR;
		return LEN_TRIPLE;
	endfunction

	// Predict the characters released by one accepted byte and queue them
	task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [2:0][BYTE_W-1:0] win;
		logic [1:0]             len;
		logic [CHAR_W-1:0]      burst[$];
		logic [CHAR_W-1:0]      t;
		char_t                  c;
		int                     n;
		win = '0;
		win[0] = held[0];
		win[1] = held[1];
		n = held_n;
		win[n] = b;
		n++;
		len = group_len(win, n, fin);
		while (len != LEN_NONE) begin
			case (len)
				LEN_SINGLE: begin
					if (plain(win[0])) begin
						burst.push_back(low6_char(win[0]));
					end else if (zero_mid(win[0])) begin
						burst.push_back((win[0][7:6] == 2'b00) ? TYPE_Z1_LOW : TYPE_Z1_HIGH);
						burst.push_back(zmid_char(win[0]));
					end else begin
						burst.push_back({win[0][7:6], 5'b00000} | TYPE_MARK);
						burst.push_back(low6_char(win[0]));
					end
				end
				LEN_PAIR: begin
					if (zero_mid(win[0])) begin
						t = TYPE_ZZ;
						if (win[0][7:6] != 2'b00) t = t | ZZ_FIRST_HIGH;
						if (win[1][7:6] != 2'b00) t = t | ZZ_SECOND_HIGH;
						burst.push_back(t);
						burst.push_back(zmid_char(win[0]));
						burst.push_back(zmid_char(win[1]));
					end else begin
						burst.push_back({win[0][7:6], win[1][7:6], 3'b000} | TYPE_MARK);
						burst.push_back(low6_char(win[0]));
						burst.push_back(low6_char(win[1]));
					end
				end
				default: begin
					burst.push_back({win[0][7:6], win[1][7:6], win[2][7:6], 1'b0} | TYPE_MARK);
					burst.push_back(low6_char(win[0]));
					burst.push_back(low6_char(win[1]));
					burst.push_back(low6_char(win[2]));
				end
			endcase
			win = win >> (BYTE_W * len);
			n -= len;
			len = group_len(win, n, fin);
		end
		held_n = n;
		held[0] = win[0];
		held[1] = win[1];
		// run_last sits on the final char this byte releases
		foreach (burst[i]) begin
			c.code = burst[i];
			c.last = (i == burst.size() - 1);
			owed_chars.push_back(c);
		end
	endtask

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch at char %0d: %s", $realtime, chars_out, msg);
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic fin);
		byte_item_t it;
		it.b = b;
		it.fin = fin;
		byte_items.push_back(it);
	endtask

	// Random byte, biased toward high bytes (and 11 top pairs) so that
	// pair/triple grouping and the 0x7F split get plenty of traffic
	task automatic queue_random_byte();
		int               kind;
		logic [1:0]       top;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(99);
		top = ($urandom_range(4) < 2) ? 2'b11 : 2'($urandom_range(3, 1));
		if (kind < 50)
			b = {top, 2'($urandom_range(3, 1)), 4'($urandom)};
		else if (kind < 75)
			b = {2'($urandom), 2'b00, 4'($urandom)};
		else if (kind < 90)
			b = {2'b00, 2'($urandom_range(3, 1)), 4'($urandom)};
		else
			b = 8'($urandom);
		queue_byte(b, $urandom_range(9) == 0);
	endtask

	// Sender hold-off: nothing queued, nothing offered, every char received,
	// then a settle wait for a byte that was only held
	task automatic wait_drain();
		while (byte_items.size() != 0 || byte_ch.valid || owed_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	//------------------------------------------------------------------
	// Driver: offers one byte per transaction. Prediction happens on the
	// edge where the byte is taken, so the owed chars are queued in order.
	//------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.in_byte   <= '0;
			byte_ch.block_end <= 1'b0;
			held_n = 0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (byte_ch.valid) begin
				encode_byte(byte_ch.in_byte, byte_ch.block_end);
				bytes_in++;
				if (byte_ch.block_end) ends_in++;
			end
			if (byte_items.size() != 0 && $urandom_range(99) >= src_idle) begin
				nxt = byte_items.pop_front();
				byte_ch.valid     <= 1'b1;
				byte_ch.in_byte   <= nxt.b;
				byte_ch.block_end <= nxt.fin;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Monitor: random backpressure, each received char checked against
	// the oldest owed one.
	//------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_ch.ready <= 1'b0;
		end else begin
			if (char_ch.valid && char_ch.ready) begin
				if (owed_chars.size() == 0) begin
					flag_mismatch($sformatf("unexpected char 0x%02h", char_ch.out_char));
				end else begin
					want = owed_chars.pop_front();
					if (char_ch.out_char !== want.code)
						flag_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
							char_ch.out_char, want.code));
					if (char_ch.run_last !== want.last)
						flag_mismatch($sformatf("run_last %b, want %b",
							char_ch.run_last, want.last));
				end
				chars_out++;
			end
			char_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars still owed", cycles, owed_chars.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// reset from time zero; driver and monitor park their outputs meanwhile
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes and every grouping rule
		queue_byte(8'h3F, 1'b0); // plain byte, top of range
		queue_byte(8'h00, 1'b1); // lone zero-middle, low top, flushed
		queue_byte(8'hFF, 1'b1); // lone high byte, flushed
		queue_byte(8'h00, 1'b0); // held only, no chars
		queue_byte(8'h0F, 1'b0); // Z Z, both tops low
		queue_byte(8'h8A, 1'b0);
		queue_byte(8'h05, 1'b0); // Z Z, first top high
		queue_byte(8'h0A, 1'b0);
		queue_byte(8'hC3, 1'b0); // Z Z, second top high
		queue_byte(8'h40, 1'b0);
		queue_byte(8'hF0, 1'b0); // Z then H: Z alone with high top, H held
		queue_byte(8'h50, 1'b0);
		queue_byte(8'h20, 1'b0); // plain behind H H: H H pair, then plain
		queue_byte(8'h9C, 1'b0);
		queue_byte(8'h4F, 1'b0); // H then Z: H alone, Z held
		queue_byte(8'h31, 1'b0); // plain behind Z: Z alone with high top
		queue_byte(8'h65, 1'b0);
		queue_byte(8'hA6, 1'b1); // H H at block end
		queue_byte(8'hD0, 1'b0);
		queue_byte(8'h7B, 1'b0);
		queue_byte(8'h19, 1'b0); // third byte plain: H H pair, then plain
		queue_byte(8'hF1, 1'b0);
		queue_byte(8'hEE, 1'b0);
		queue_byte(8'hD7, 1'b0); // three 11 tops: split into pair + held
		queue_byte(8'h95, 1'b0);
		queue_byte(8'h6A, 1'b1); // H H H triple
		wait_drain();

		// Random, busy sender / lazy receiver and the reverse, then full rate
		src_idle = 35;
		snk_idle = 46;
		repeat (ITEMS_PER_PH) queue_random_byte();
		wait_drain();

		src_idle = 46;
		snk_idle = 35;
		repeat (ITEMS_PER_PH) queue_random_byte();
		wait_drain();

		src_idle = 0;
		snk_idle = 0;
		repeat (ITEMS_PER_PH) queue_random_byte();
		wait_drain();

		$display("Covered %0d bytes (%0d block ends) and %0d chars checked, %0d mismatches",
			bytes_in, ends_in, chars_out, errors);
		$display("Backpressure phases: sender-idle, receiver-idle, and no idling");
		if (errors == 0 && owed_chars.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: binary_to_printable_encoder.f
src/bpe_pkg.sv
src/bpe_byte_if.sv
src/bpe_char_if.sv
src/bpe_group.sv
src/binary_to_printable_encoder.sv
verif/tb_binary_to_printable_encoder.sv
